// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the periodic task scheduler table.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'd0,
    SL_WAIT  = 2'd1,
    SL_READY = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_SEL,
    S_RD,
    S_UPD
  } state_t;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SRT  = 2'd1;
  localparam logic [1:0] POL_EDF  = 2'd2;
  localparam logic [1:0] POL_RM   = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pts_mem.sv -----
// ----------------------------------------------------------------------------
// pts_mem
// Per-slot task record store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 81
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/pts_pick.sv -----
// ----------------------------------------------------------------------------
// pts_pick
// Running best-candidate tracker for the selection pass.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_pick #(
  parameter int TIME_BITS = 16,
  parameter int SB        = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 cand_en,
  input  wire logic [1:0]           policy,
  input  wire logic [SB-1:0]        cand_slot,
  input  wire logic [TIME_BITS-1:0] cand_rel,
  input  wire logic [15:0]          cand_units,
  input  wire logic [15:0]          cand_size,
  input  wire logic [15:0]          cand_per,
  input  wire logic [15:0]          cand_age,
  output logic                      found,
  output logic      [SB-1:0]        best_slot
);

  localparam int KW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

  logic [KW-1:0] b_key;
  logic [15:0]   b_size;
  logic [15:0]   b_age;
  logic [KW-1:0] c_key;
  logic          wins;

  always_comb begin
    case (policy)
      pts_pkg::POL_SRT: c_key = KW'(cand_units);
      pts_pkg::POL_EDF: c_key = KW'(cand_rel) + KW'(cand_per);
      pts_pkg::POL_RM:  c_key = KW'(cand_per);
      default:          c_key = '0;
    endcase
    if (!found) begin
      wins = 1'b1;
    end else if (c_key != b_key) begin
      wins = c_key < b_key;
    end else if (policy[1] && cand_size != b_size) begin
      wins = cand_size < b_size;
    end else begin
      wins = cand_age > b_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (cand_en && wins) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_en && wins) begin
      best_slot <= cand_slot;
      b_key     <= c_key;
      b_size    <= cand_size;
      b_age     <= cand_age;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/periodic_task_scheduler_table_core.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_table_core
// Task table with release, policy selection and one-unit execution per tick.
//
// channel   signals                                         dir
// command   start, busy, command, task_slot, release_time,  in
//           run_length, task_period
// result    done, ran, task_id, deadline_missed,            out
//           job_finished, tick_time, total_*
// config    cfg_we, cfg_data                                in
//
// A load's result strobes on the next cycle after it is accepted.
// A tick makes one memory pass for release, one for selection, then, if a task
// was selected, a re-read of the winner and its write-back.
// busy is high during a tick. Results cannot be stalled.
// rst is synchronous; it empties all slots and clears time and sums.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_task_scheduler_table_core #(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [3:0]  task_slot,
  input  wire logic [15:0] release_time,
  input  wire logic [15:0] run_length,
  input  wire logic [15:0] task_period,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_data,
  output logic             done,
  output logic             ran,
  output logic      [3:0]  task_id,
  output logic             deadline_missed,
  output logic             job_finished,
  output logic      [15:0] tick_time,
  output logic      [31:0] total_completion,
  output logic      [31:0] total_waiting,
  output logic      [31:0] total_response
);

  localparam int SB = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CB = SB + 1;
  localparam int KW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  localparam int W  = TIME_BITS + 65;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  pts_pkg::state_t   state, state_next;
  pts_pkg::slot_st_t status [TASK_SLOTS];

  logic [1:0]           policy;
  logic [TIME_BITS-1:0] cur_time;
  logic [15:0]          seq_counter;
  logic [31:0]          comp_sum, wait_sum, resp_sum;
  logic [CB-1:0]        cnt;
  logic [CB-1:0]        cnt_new;
  logic                 rv;
  logic [SB-1:0]        ra;

  logic                 we;
  logic [SB-1:0]        waddr, raddr;
  logic [W-1:0]         wdata, rdata;

  logic [TIME_BITS-1:0] m_rel;
  logic [15:0]          m_units, m_size, m_per, m_seq;
  logic                 m_ever;

  logic                 accept, issue, slot_ok, rel_hit, cand_en;
  logic                 found;
  logic [SB-1:0]        best;
  logic [TIME_BITS-1:0] rel_c, t1, new_rel;
  logic [KW-1:0]        rel_per, due, term;
  logic                 missed, fin;
  logic [15:0]          new_units;
  logic [CB-1:0]        n_adj;

  assign accept  = start && !busy;
  assign busy    = state != pts_pkg::S_IDLE;
  assign slot_ok = int'(task_slot) < TASK_SLOTS;
  assign issue   = (state == pts_pkg::S_REL || state == pts_pkg::S_SEL)
                   && cnt < CB'(TASK_SLOTS);
  assign raddr   = (state == pts_pkg::S_RD) ? best : cnt[SB-1:0];

  assign m_rel   = rdata[W-1 -: TIME_BITS];
  assign m_units = rdata[64:49];
  assign m_size  = rdata[48:33];
  assign m_per   = rdata[32:17];
  assign m_ever  = rdata[16];
  assign m_seq   = rdata[15:0];

  assign rel_c   = (33'(release_time) > 33'(TMAX)) ? TMAX : TIME_BITS'(release_time);
  assign rel_hit = rv && status[ra] == pts_pkg::SL_WAIT && m_rel <= cur_time;
  assign cand_en = state == pts_pkg::S_SEL && rv && status[ra] == pts_pkg::SL_READY;

  assign t1      = (cur_time == TMAX) ? cur_time : cur_time + 1'b1;
  assign rel_per = KW'(m_rel) + KW'(m_per);
  assign missed  = m_per != 16'd0 && KW'(cur_time) >= rel_per;
  assign fin     = m_units <= 16'd1;
  assign due     = KW'(m_rel) + KW'(m_size);
  assign term    = (KW'(t1) > due) ? KW'(t1) - due : '0;
  assign new_rel = (fin && m_per != 16'd0)
                   ? ((rel_per > KW'(TMAX)) ? TMAX : TIME_BITS'(rel_per)) : m_rel;
  assign new_units = fin ? ((m_per != 16'd0) ? m_size : 16'd0) : m_units - 16'd1;
  assign n_adj   = cnt_new - CB'(found && !m_ever);

  pts_mem #(.DEPTH(TASK_SLOTS), .AW(SB), .W(W)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pts_pick #(.TIME_BITS(TIME_BITS), .SB(SB)) u_pick (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .cand_en    (cand_en),
    .policy     (policy),
    .cand_slot  (ra),
    .cand_rel   (m_rel),
    .cand_units (m_units),
    .cand_size  (m_size),
    .cand_per   (m_per),
    .cand_age   (seq_counter - m_seq),
    .found      (found),
    .best_slot  (best)
  );

  always_comb begin
    we    = 1'b0;
    waddr = ra;
    wdata = rdata;
    unique case (state)
      pts_pkg::S_IDLE: begin
        if (accept && command == pts_pkg::CMD_LOAD && slot_ok) begin
          we    = 1'b1;
          waddr = SB'(task_slot);
          wdata = {rel_c, run_length, run_length, task_period, 1'b0, 16'h0000};
        end
      end
      pts_pkg::S_REL: begin
        if (rel_hit) begin
          we    = 1'b1;
          wdata = {rdata[W-1:16], seq_counter};
        end
      end
      pts_pkg::S_UPD: begin
        if (found) begin
          we    = 1'b1;
          waddr = best;
          wdata = {new_rel, new_units, m_size, m_per, 1'b1, m_seq};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pts_pkg::S_IDLE:
        if (accept && command == pts_pkg::CMD_TICK) state_next = pts_pkg::S_REL;
      pts_pkg::S_REL:
        if (!issue && !rv) state_next = pts_pkg::S_SEL;
      pts_pkg::S_SEL:
        if (!issue && !rv) state_next = found ? pts_pkg::S_RD : pts_pkg::S_UPD;
      pts_pkg::S_RD:
        state_next = pts_pkg::S_UPD;
      pts_pkg::S_UPD:
        state_next = pts_pkg::S_IDLE;
      default:
        state_next = pts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pts_pkg::S_IDLE;
      policy      <= pts_pkg::POL_FCFS;
      cur_time    <= '0;
      seq_counter <= '0;
      comp_sum    <= '0;
      wait_sum    <= '0;
      resp_sum    <= '0;
      done        <= 1'b0;
      rv          <= 1'b0;
      cnt         <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        status[i] <= pts_pkg::SL_EMPTY;
      end
    end else begin
      done  <= 1'b0;
      state <= state_next;
      rv    <= issue;
      if (cfg_we) begin
        policy <= cfg_data;
      end
      if (issue) begin
        cnt <= cnt + 1'b1;
        ra  <= cnt[SB-1:0];
      end
      unique case (state)
        pts_pkg::S_IDLE: begin
          cnt     <= '0;
          cnt_new <= '0;
          if (accept && command == pts_pkg::CMD_LOAD) begin
            if (slot_ok) begin
              status[SB'(task_slot)] <= pts_pkg::SL_WAIT;
              comp_sum <= pts_pkg::sat_add32(comp_sum, 32'(run_length));
            end
            done            <= 1'b1;
            ran             <= 1'b0;
            task_id         <= 4'd0;
            deadline_missed <= 1'b0;
            job_finished    <= 1'b0;
            tick_time       <= (33'(cur_time) > 33'(16'hFFFF)) ? 16'hFFFF : 16'(cur_time);
          end
        end
        pts_pkg::S_REL: begin
          if (rel_hit) begin
            status[ra]  <= pts_pkg::SL_READY;
            seq_counter <= seq_counter + 16'd1;
            resp_sum    <= pts_pkg::sat_add32(resp_sum, 32'(cur_time - m_rel));
          end
          if (!issue && !rv) begin
            cnt <= '0;
          end
        end
        pts_pkg::S_SEL: begin
          if (cand_en && !m_ever) begin
            cnt_new <= cnt_new + 1'b1;
          end
        end
        pts_pkg::S_RD: ;
        pts_pkg::S_UPD: begin
          done            <= 1'b1;
          ran             <= found;
          task_id         <= found ? 4'(best) : 4'd0;
          deadline_missed <= found && missed;
          job_finished    <= found && fin;
          tick_time       <= (33'(cur_time) > 33'(16'hFFFF)) ? 16'hFFFF : 16'(cur_time);
          cur_time        <= t1;
          if (found) begin
            if (fin) begin
              status[best] <= (m_per != 16'd0) ? pts_pkg::SL_WAIT : pts_pkg::SL_EMPTY;
              comp_sum <= pts_pkg::sat_add32(comp_sum, 32'(term));
              wait_sum <= pts_pkg::sat_add32(wait_sum, 32'(term));
            end
            if (cur_time != TMAX) begin
              resp_sum <= pts_pkg::sat_add32(resp_sum, 32'(n_adj));
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign total_completion = comp_sum;
  assign total_waiting    = wait_sum;
  assign total_response   = resp_sum;

  a_tick_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && command == pts_pkg::CMD_TICK) |=> busy)
    else $error("tick transfer did not start a scan");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == pts_pkg::S_UPD) || $past(accept && command == pts_pkg::CMD_LOAD)))
    else $error("result strobe without a finished command");

  a_fin_needs_ran: assert property (@(posedge clk) disable iff (rst)
    (done && (job_finished || deadline_missed)) |-> ran)
    else $error("job flags set on a result where no task ran");

endmodule
`default_nettype wire
